// ===== rtl/vcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_pkg: shared types and constants of the vending coin controller
// Event codes, status codes, job word between front and back, price and
// denomination tables.
// ----------------------------------------------------------------------------
package vcc_pkg;

	// highest valid product number
	localparam logic [3:0] PRODUCT_COUNT = 4'd15;

	// job queue depth (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_SELECT = 2'd0,
		OP_INSERT = 2'd1,
		OP_SEND   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_COIN_OK      = 3'd0,
		ST_COIN_REJECT  = 3'd1,
		ST_SELECTED     = 3'd2,
		ST_BAD_PRODUCT  = 3'd3,
		ST_VENDED       = 3'd4,
		ST_INSUFFICIENT = 3'd5,
		ST_NO_SELECTION = 3'd6,
		ST_CREDIT_FULL  = 3'd7
	} status_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_SUB,
		B_SPLIT,
		B_EMIT
	} back_state_t;

	// one job from the front to the back
	typedef struct packed {
		logic        vend;
		status_t     status;
		logic [3:0]  product;
		logic [15:0] change;
	} job_t;

	// price in cents of each product (entry 0 unused)
	function automatic logic [7:0] price_of(input logic [3:0] p);
		logic [7:0] r;
		case (p)
			4'd1:    r = 8'd200;
			4'd2:    r = 8'd175;
			4'd3:    r = 8'd155;
			4'd4:    r = 8'd125;
			4'd5:    r = 8'd105;
			4'd6:    r = 8'd90;
			4'd7:    r = 8'd65;
			4'd8:    r = 8'd45;
			4'd9:    r = 8'd20;
			4'd10:   r = 8'd35;
			4'd11:   r = 8'd10;
			4'd12:   r = 8'd5;
			4'd13:   r = 8'd15;
			4'd14:   r = 8'd15;
			4'd15:   r = 8'd5;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// change denominations, largest first
	function automatic logic [7:0] denom_of(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0:    r = 8'd200;
			3'd1:    r = 8'd100;
			3'd2:    r = 8'd50;
			3'd3:    r = 8'd10;
			3'd4:    r = 8'd5;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/vcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_front: event decode and machine state
// Takes one event word per cycle while the job queue has room, keeps credit
// and selection, and turns each event into a job for the back end.
// ----------------------------------------------------------------------------
module vcc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  logic [7:0]    coin_value,
	input  logic [3:0]    product_number,
	input  logic          queue_full,
	output logic          job_push,
	output vcc_pkg::job_t job
);
	import vcc_pkg::*;

	logic [15:0] credit_q;
	logic [3:0]  sel_prod_q;
	logic        sel_valid_q;

	logic        accept;
	logic [16:0] coin_sum;
	logic [7:0]  price;
	logic        coin_ok;
	logic        prod_ok;

	logic [15:0] credit_d;
	logic [3:0]  sel_prod_d;
	logic        sel_valid_d;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign coin_sum = {1'b0, credit_q} + {9'd0, coin_value};
	assign price    = price_of(sel_prod_q);
	assign coin_ok  = coin_value inside {8'd5, 8'd10, 8'd50, 8'd100, 8'd200};
	assign prod_ok  = (product_number != 4'd0) && (product_number <= PRODUCT_COUNT);

	// classify the event and work out the next state
	always_comb begin
		credit_d    = credit_q;
		sel_prod_d  = sel_prod_q;
		sel_valid_d = sel_valid_q;
		job_push    = 1'b0;
		job.vend    = 1'b0;
		job.status  = ST_COIN_OK;
		job.product = 4'd0;
		job.change  = 16'd0;
		if (accept) begin
			case (opcode_t'(opcode))
				OP_SELECT: begin
					job_push = 1'b1;
					if (prod_ok) begin
						sel_prod_d  = product_number;
						sel_valid_d = 1'b1;
						job.status  = ST_SELECTED;
					end else begin
						job.status = ST_BAD_PRODUCT;
					end
				end
				OP_INSERT: begin
					job_push = 1'b1;
					if (!coin_ok) begin
						job.status = ST_COIN_REJECT;
					end else if (coin_sum[16]) begin
						job.status = ST_CREDIT_FULL;
					end else begin
						credit_d   = coin_sum[15:0];
						job.status = ST_COIN_OK;
					end
				end
				OP_SEND: begin
					job_push = 1'b1;
					if (!sel_valid_q) begin
						job.status = ST_NO_SELECTION;
					end else if (credit_q < {8'd0, price}) begin
						job.status = ST_INSUFFICIENT;
					end else begin
						job.vend    = 1'b1;
						job.status  = ST_VENDED;
						job.product = sel_prod_q;
						job.change  = credit_q - {8'd0, price};
						credit_d    = 16'd0;
						sel_prod_d  = 4'd0;
						sel_valid_d = 1'b0;
					end
				end
				default: begin
					job_push = 1'b0;
				end
			endcase
		end
	end

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q    <= 16'd0;
			sel_prod_q  <= 4'd0;
			sel_valid_q <= 1'b0;
		end else begin
			credit_q    <= credit_d;
			sel_prod_q  <= sel_prod_d;
			sel_valid_q <= sel_valid_d;
		end
	end

endmodule

// ===== rtl/vcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_queue: job queue between front and back
// Small first-in first-out buffer of job words.
// ----------------------------------------------------------------------------
module vcc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vcc_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output vcc_pkg::job_t pop_data
);
	import vcc_pkg::*;

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/vcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_back: result generation and greedy change sequencer
// Pops jobs, splits vend change into denominations and drives the
// registered result word.
// ----------------------------------------------------------------------------
module vcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  vcc_pkg::job_t job,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [3:0]    vended_product,
	output logic [7:0]    change_coin,
	output logic [8:0]    coin_count,
	output logic          last
);
	import vcc_pkg::*;

	back_state_t state_q, state_d;

	logic [15:0] rest_q;
	logic [3:0]  prod_q;
	logic [8:0]  q200_q;
	logic [7:0]  rest8_q;
	logic        c100_q, c50_q, c5_q;
	logic [2:0]  c10_q;
	logic [4:0]  mask_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [3:0]  prod_out_q;
	logic [7:0]  coin_q;
	logic [8:0]  count_q;
	logic        last_q;

	logic        slot_free;
	logic [28:0] recip_prod;
	logic [16:0] mul200;
	logic [16:0] rest_sub;

	// small denomination split
	logic        c100, c50, c5;
	logic [7:0]  r1, r2, r3;
	logic [2:0]  c10;
	logic [7:0]  tens;

	// emit selection
	logic [2:0]  sel;
	logic [4:0]  rem_mask;
	logic [8:0]  sel_count;

	// output word load
	logic        emit;
	logic [2:0]  emit_status;
	logic [3:0]  emit_prod;
	logic [7:0]  emit_coin;
	logic [8:0]  emit_count;
	logic        emit_last;
	logic        mask_upd;

	assign slot_free = !out_valid_q || out_ready;

	// divide by 200: (rest >> 3) / 25 by reciprocal, exact for 13 bits
	assign recip_prod = 29'(rest_q[15:3]) * 29'd41944;

	// remainder after the 200 coins
	assign mul200   = 17'(q200_q) * 17'd200;
	assign rest_sub = {1'b0, rest_q} - mul200;

	// split of the remainder below 200
	always_comb begin
		c100 = (rest8_q >= 8'd100);
		r1   = c100 ? (rest8_q - 8'd100) : rest8_q;
		c50  = (r1 >= 8'd50);
		r2   = c50 ? (r1 - 8'd50) : r1;
		if (r2 >= 8'd40) begin
			c10 = 3'd4; tens = 8'd40;
		end else if (r2 >= 8'd30) begin
			c10 = 3'd3; tens = 8'd30;
		end else if (r2 >= 8'd20) begin
			c10 = 3'd2; tens = 8'd20;
		end else if (r2 >= 8'd10) begin
			c10 = 3'd1; tens = 8'd10;
		end else begin
			c10 = 3'd0; tens = 8'd0;
		end
		r3 = r2 - tens;
		c5 = (r3 >= 8'd5);
	end

	// largest denomination still owed
	always_comb begin
		sel = 3'd0;
		for (int i = 4; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 3'(i);
			end
		end
		rem_mask = mask_q & ~(5'b00001 << sel);
		case (sel)
			3'd0:    sel_count = q200_q;
			3'd1:    sel_count = {8'd0, c100_q};
			3'd2:    sel_count = {8'd0, c50_q};
			3'd3:    sel_count = {6'd0, c10_q};
			3'd4:    sel_count = {8'd0, c5_q};
			default: sel_count = 9'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (job_valid && slot_free && job.vend) begin
					state_d = B_DIV;
				end
			end
			B_DIV:   state_d = B_SUB;
			B_SUB:   state_d = B_SPLIT;
			B_SPLIT: state_d = B_EMIT;
			B_EMIT: begin
				if (slot_free && (mask_q == 5'd0 || rem_mask == 5'd0)) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		job_pop     = 1'b0;
		emit        = 1'b0;
		emit_status = ST_VENDED;
		emit_prod   = 4'd0;
		emit_coin   = 8'd0;
		emit_count  = 9'd0;
		emit_last   = 1'b1;
		mask_upd    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (job_valid && slot_free) begin
					job_pop     = 1'b1;
					emit        = !job.vend;
					emit_status = job.status;
				end
			end
			B_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					mask_upd  = 1'b1;
					emit_prod = prod_q;
					if (mask_q != 5'd0) begin
						emit_coin  = denom_of(sel);
						emit_count = sel_count;
						emit_last  = (rem_mask == 5'd0);
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			rest_q <= job.change;
			prod_q <= job.product;
		end
		if (state_q == B_DIV) begin
			q200_q <= recip_prod[28:20];
		end
		if (state_q == B_SUB) begin
			rest8_q <= rest_sub[7:0];
		end
		if (state_q == B_SPLIT) begin
			c100_q <= c100;
			c50_q  <= c50;
			c10_q  <= c10;
			c5_q   <= c5;
			mask_q <= {c5, (c10 != 3'd0), c50, c100, (q200_q != 9'd0)};
		end else if (mask_upd) begin
			mask_q <= rem_mask;
		end
		if (emit) begin
			status_q   <= emit_status;
			prod_out_q <= emit_prod;
			coin_q     <= emit_coin;
			count_q    <= emit_count;
			last_q     <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign vended_product = prod_out_q;
	assign change_coin    = coin_q;
	assign coin_count     = count_q;
	assign last           = last_q;

endmodule

// ===== rtl/vending_coin_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vending_coin_controller_core: vending controller with greedy change
// Top level: event front end, job queue, change back end.
// ----------------------------------------------------------------------------
// Each input word is one event (select, insert coin, send). The front end
// decodes it and updates credit and selection in the cycle it is taken, so
// events enter back to back while a four-entry job queue has room. A select,
// insert or refused send yields one registered result word once the back end
// takes it from the queue. A vend yields 1 to 5 change words: the change
// sequencer steps through reciprocal divide by 200, remainder and small-coin
// split, then issues the change words in turn, each once the output has room.
module vending_coin_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], coin_value[9:2], product_number[13:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // status[2:0], vended_product[6:3],
	                              // change_coin[14:7], coin_count[23:15]
	output logic        m_tlast
);
	import vcc_pkg::*;

	job_t front_job;
	job_t back_job;
	logic job_push;
	logic job_pop;
	logic queue_full;
	logic queue_valid;

	logic [2:0] status;
	logic [3:0] vended_product;
	logic [7:0] change_coin;
	logic [8:0] coin_count;

	// event decode
	vcc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.opcode         (s_tdata[1:0]),
		.coin_value     (s_tdata[9:2]),
		.product_number (s_tdata[13:10]),
		.queue_full     (queue_full),
		.job_push       (job_push),
		.job            (front_job)
	);

	// job queue
	vcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (front_job),
		.full      (queue_full),
		.pop       (job_pop),
		.valid     (queue_valid),
		.pop_data  (back_job)
	);

	// result and change generation
	vcc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (queue_valid),
		.job            (back_job),
		.job_pop        (job_pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.status         (status),
		.vended_product (vended_product),
		.change_coin    (change_coin),
		.coin_count     (coin_count),
		.last           (m_tlast)
	);

	assign m_tdata = {coin_count, change_coin, vended_product, status};

endmodule

// ===== rtl/vcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_checker: port-level checks of the vending controller
// Watches the result stream and checks word consistency.
// ----------------------------------------------------------------------------
module vcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);
	import vcc_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// change coins only come with a vend
	a_change_vend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14:7] != 8'd0 |-> m_tdata[2:0] == ST_VENDED)
		else $error("change coin without vend status");

	// a change word always carries a nonzero count
	a_change_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14:7] != 8'd0 |-> m_tdata[23:15] != 9'd0)
		else $error("change coin with zero count");

	// non-vend results are single, empty words
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_VENDED |-> m_tlast && m_tdata[23:3] == 21'd0)
		else $error("non-vend result not a single empty word");

endmodule

bind vending_coin_controller_core vcc_checker u_vcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
